// ===== design/fehm_pkg.sv =====
package fehm_pkg;

    localparam int FIRE_WIDTH  = 56;
    localparam int FIRE_HEIGHT = 56;
    localparam int HEAT_LEVELS = 256;

    localparam int MAP_DEPTH = FIRE_WIDTH * FIRE_HEIGHT;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int HEAT_W    = 8;
    localparam int COORD_W   = 6;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [HEAT_W-1:0]  heat_t;
    typedef logic [COORD_W-1:0] coord_t;

    // operation codes
    localparam logic [1:0] OP_PLAN    = 2'd0;
    localparam logic [1:0] OP_SEED    = 2'd1;
    localparam logic [1:0] OP_COOL    = 2'd2;
    localparam logic [1:0] OP_ADVANCE = 2'd3;

    localparam heat_t HEAT_MASK = HEAT_W'(HEAT_LEVELS - 1);

    // map addresses, row-major with row 0 at the top
    localparam addr_t BOTTOM_BASE = ADDR_W'((FIRE_HEIGHT - 1) * FIRE_WIDTH);
    localparam addr_t FRAME_START = ADDR_W'((FIRE_HEIGHT - 2) * FIRE_WIDTH + 1);
    localparam addr_t ROW_BACK    = ADDR_W'(2 * FIRE_WIDTH - 3);
    localparam addr_t OFS_BELOW_L = ADDR_W'(FIRE_WIDTH - 1);
    localparam addr_t OFS_BELOW   = ADDR_W'(FIRE_WIDTH);
    localparam addr_t OFS_BELOW_R = ADDR_W'(FIRE_WIDTH + 1);
    localparam addr_t LAST_ADDR   = ADDR_W'(MAP_DEPTH - 1);

    localparam coord_t ROW_FIRST = COORD_W'(FIRE_HEIGHT - 2);
    localparam coord_t COL_FIRST = COORD_W'(1);
    localparam coord_t COL_LAST  = COORD_W'(FIRE_WIDTH - 2);

endpackage

// ===== design/fehm_ram.sv =====
module fehm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/fire_effect_heat_map.sv =====
// Fire heat map: a 56 x 56 map of 8-bit heat values held in one RAM.
// Input channel (in_valid / in_stall) carries one item per transfer:
//   plan    - returns hot and cool spot counts for the frame
//   seed    - writes seed_heat to a bottom-row column, no result
//   cool    - writes half of one bottom-row cell to another, no result
//   advance - updates the next pixel, columns 1..54, rows 54 up to 0, returns it
// Output channel (out_valid / out_stall) carries one result per plan or
// advance item, from an output register.
// Sequence, from the accepting edge: a plan result goes to the result
// registers, then from the done state to the output register; an advance
// passes read steps 0 to 4 and then the done state; a seed is written as it
// is taken and a cool writes in a second state. The advance sequence is set
// by the single RAM read port: the pixel and its three lower neighbours are
// fetched one per cycle through a shared address adder and summed in one
// accumulator. in_stall is high whenever the sequencer is not idle.
// The output register lets a new item be taken while a result waits; a
// finished result is held inside until the output register frees up.
// Reset: after rst_n falls, a clearing pass writes zero to all 3136 map
// entries, one per cycle; in_stall stays high until the pass is done.
// The cursor restarts at row 54, column 1.
module fire_effect_heat_map (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [7:0] load_percent,
    input  logic       fixed_flame,
    input  logic [5:0] column,
    input  logic [7:0] seed_heat,
    input  logic [5:0] source_column,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [5:0] hot_spot_count,
    output logic [2:0] cool_spot_count,
    output logic [5:0] pixel_x,
    output logic [5:0] pixel_y,
    output logic [7:0] pixel_heat,
    output logic       end_of_frame
);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_COOL_WR = 3'd2;
    localparam logic [2:0] ST_ADV     = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    localparam logic [5:0] FLAME_HOT = 6'd10;
    localparam logic [5:0] HOT_BASE  = 6'd2;
    localparam logic [7:0] LOAD_KNEE = 8'd100;
    localparam logic [2:0] STEP_LAST = 3'd4;

    // control
    logic [2:0]     state_reg, state_next;
    logic [2:0]     step_reg, step_next;
    fehm_pkg::addr_t clr_addr_reg, clr_addr_next;
    fehm_pkg::addr_t cur_addr_reg, cur_addr_next;
    fehm_pkg::coord_t cur_row_reg, cur_row_next;
    fehm_pkg::coord_t cur_col_reg, cur_col_next;
    logic           out_valid_reg, out_valid_next;

    // payload
    logic [9:0]     sum_reg, sum_next;
    logic [5:0]     dst_col_reg, dst_col_next;
    logic [5:0]     res_hot_reg, res_hot_next;
    logic [2:0]     res_cool_reg, res_cool_next;
    logic [5:0]     res_x_reg, res_x_next;
    logic [5:0]     res_y_reg, res_y_next;
    logic [7:0]     res_heat_reg, res_heat_next;
    logic           res_eof_reg, res_eof_next;
    logic [5:0]     out_hot_reg;
    logic [2:0]     out_cool_reg;
    logic [5:0]     out_x_reg;
    logic [5:0]     out_y_reg;
    logic [7:0]     out_heat_reg;
    logic           out_eof_reg;

    // RAM and shared address adder
    logic            ram_we;
    fehm_pkg::addr_t ram_waddr;
    fehm_pkg::heat_t ram_wdata;
    fehm_pkg::heat_t ram_rdata;
    fehm_pkg::addr_t addr_base;
    fehm_pkg::addr_t addr_ofs;
    fehm_pkg::addr_t addr_sum;

    logic       in_accept;
    logic       out_free;
    logic       col_ok;
    logic       src_ok;
    logic [5:0] plan_hot;
    logic [2:0] plan_cool;
    logic [7:0] load_gap;
    logic [7:0] new_heat;

    fehm_ram #(
        .WIDTH (fehm_pkg::HEAT_W),
        .DEPTH (fehm_pkg::MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_sum),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign col_ok = (int'(column) < fehm_pkg::FIRE_WIDTH);
    assign src_ok = (int'(source_column) < fehm_pkg::FIRE_WIDTH);

    // plan arithmetic
    assign load_gap  = LOAD_KNEE - load_percent;
    assign plan_hot  = fixed_flame ? FLAME_HOT : ({1'b0, load_percent[7:3]} + HOT_BASE);
    assign plan_cool = (fixed_flame || load_percent >= LOAD_KNEE) ? 3'd0 : load_gap[6:4];

    // shared address adder: bottom row plus column, or cursor plus neighbour offset
    always_comb
    begin
        addr_base = fehm_pkg::BOTTOM_BASE;
        addr_ofs  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (operation == fehm_pkg::OP_SEED)
                begin
                    addr_ofs = fehm_pkg::ADDR_W'(column);
                end
                else
                begin
                    addr_ofs = fehm_pkg::ADDR_W'(source_column);
                end
            end
            ST_COOL_WR:
            begin
                addr_ofs = fehm_pkg::ADDR_W'(dst_col_reg);
            end
            ST_ADV:
            begin
                addr_base = cur_addr_reg;
                case (step_reg)
                    3'd1:    addr_ofs = fehm_pkg::OFS_BELOW_L;
                    3'd2:    addr_ofs = fehm_pkg::OFS_BELOW;
                    3'd3:    addr_ofs = fehm_pkg::OFS_BELOW_R;
                    default: addr_ofs = '0;
                endcase
            end
            default:
            begin
                addr_ofs = '0;
            end
        endcase
    end

    assign addr_sum = addr_base + addr_ofs;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        clr_addr_next  = clr_addr_reg;
        cur_addr_next  = cur_addr_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        sum_next       = sum_reg;
        dst_col_next   = dst_col_reg;
        res_hot_next   = res_hot_reg;
        res_cool_next  = res_cool_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_heat_next  = res_heat_reg;
        res_eof_next   = res_eof_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_sum;
        ram_wdata      = '0;
        new_heat       = '0;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == fehm_pkg::LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (operation)
                        fehm_pkg::OP_PLAN:
                        begin
                            res_hot_next  = plan_hot;
                            res_cool_next = plan_cool;
                            res_x_next    = '0;
                            res_y_next    = '0;
                            res_heat_next = '0;
                            res_eof_next  = 1'b0;
                            state_next    = ST_DONE;
                        end
                        fehm_pkg::OP_SEED:
                        begin
                            ram_we    = col_ok;
                            ram_wdata = seed_heat & fehm_pkg::HEAT_MASK;
                        end
                        fehm_pkg::OP_COOL:
                        begin
                            // source read is issued now, write lands next cycle
                            dst_col_next = column;
                            if (col_ok && src_ok)
                            begin
                                state_next = ST_COOL_WR;
                            end
                        end
                        default:
                        begin
                            sum_next   = '0;
                            step_next  = '0;
                            state_next = ST_ADV;
                        end
                    endcase
                end
            end
            ST_COOL_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = {1'b0, ram_rdata[7:1]};
                state_next = ST_IDLE;
            end
            ST_ADV:
            begin
                // read issued in steps 0..3, data accumulated one step later
                step_next = step_reg + 1'b1;
                if (step_reg != 3'd0)
                begin
                    sum_next = sum_reg + {2'b00, ram_rdata};
                end
                if (step_reg == STEP_LAST)
                begin
                    new_heat      = sum_next[9:2];
                    ram_we        = 1'b1;
                    ram_wdata     = new_heat;
                    res_hot_next  = '0;
                    res_cool_next = '0;
                    res_x_next    = cur_col_reg;
                    res_y_next    = cur_row_reg;
                    res_heat_next = new_heat;
                    res_eof_next  = (cur_row_reg == '0) && (cur_col_reg == fehm_pkg::COL_LAST);
                    if (cur_col_reg == fehm_pkg::COL_LAST)
                    begin
                        cur_col_next = fehm_pkg::COL_FIRST;
                        if (cur_row_reg == '0)
                        begin
                            cur_row_next  = fehm_pkg::ROW_FIRST;
                            cur_addr_next = fehm_pkg::FRAME_START;
                        end
                        else
                        begin
                            cur_row_next  = cur_row_reg - 1'b1;
                            cur_addr_next = cur_addr_reg - fehm_pkg::ROW_BACK;
                        end
                    end
                    else
                    begin
                        cur_col_next  = cur_col_reg + 1'b1;
                        cur_addr_next = cur_addr_reg + 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            step_reg      <= '0;
            clr_addr_reg  <= '0;
            cur_addr_reg  <= fehm_pkg::FRAME_START;
            cur_row_reg   <= fehm_pkg::ROW_FIRST;
            cur_col_reg   <= fehm_pkg::COL_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_addr_reg  <= clr_addr_next;
            cur_addr_reg  <= cur_addr_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        dst_col_reg  <= dst_col_next;
        res_hot_reg  <= res_hot_next;
        res_cool_reg <= res_cool_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_heat_reg <= res_heat_next;
        res_eof_reg  <= res_eof_next;
        if (state_reg == ST_DONE && out_free)
        begin
            out_hot_reg  <= res_hot_reg;
            out_cool_reg <= res_cool_reg;
            out_x_reg    <= res_x_reg;
            out_y_reg    <= res_y_reg;
            out_heat_reg <= res_heat_reg;
            out_eof_reg  <= res_eof_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hot_spot_count  = out_hot_reg;
    assign cool_spot_count = out_cool_reg;
    assign pixel_x         = out_x_reg;
    assign pixel_y         = out_y_reg;
    assign pixel_heat      = out_heat_reg;
    assign end_of_frame    = out_eof_reg;

endmodule
